// File: hdl/trdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdt_pkg
// Shared types and constants for the triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
package trdt_pkg;

  localparam int NUM_W = 27;
  localparam int DEN_W = 10;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_STEP  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

endpackage

// File: hdl/trdt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdt_div
// Bit-serial floor divider: signed numerator by positive denominator,
// one quotient bit per cycle; a closing step registers result and done pulse.
// ----------------------------------------------------------------------------
module trdt_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  trdt_pkg::div_req_t               req,
  output logic                             done,
  output logic signed [trdt_pkg::NUM_W-1:0] quo
);
  import trdt_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [NUM_W-1:0]        mag_r, mag_nxt;
  logic signed [NUM_W-1:0] res_r, res_nxt;
  logic [DEN_W:0]          shifted;
  logic [DEN_W+1:0]        trial;
  logic [NUM_W-1:0]        qfix;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    mag_nxt  = mag_r;
    res_nxt  = res_r;
    shifted  = {rem_r, mag_r[NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    qfix     = mag_r + NUM_W'(rem_r != '0);
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      neg_nxt  = req.num[NUM_W-1];
      mag_nxt  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
        mag_nxt = {mag_r[NUM_W-2:0], ~trial[DEN_W+1]};
        rem_nxt = trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? $signed(-qfix) : $signed(mag_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    mag_r <= mag_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule

// File: hdl/trdt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdt_store
// Depth memory, one port, registered read. Sweeps every entry to the most
// negative depth after reset and reports busy until the sweep ends.
// ----------------------------------------------------------------------------
module trdt_store #(
  parameter int ENTRIES    = 262144,
  parameter int DEPTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          re,
  input  logic                          we,
  input  logic [$clog2(ENTRIES)-1:0]    addr,
  input  logic signed [DEPTH_BITS-1:0]  wdata,
  output logic signed [DEPTH_BITS-1:0]  rdata,
  output logic                          busy
);
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  logic signed [DEPTH_BITS-1:0] mem [ENTRIES];
  logic signed [DEPTH_BITS-1:0] rdata_r;
  logic [ADDR_W-1:0]            clr_addr_r;
  logic                         busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(ENTRIES - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= DMIN;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(clr_addr_r) == ADDR_W'(ENTRIES - 1))
    else $error("depth sweep ended early");

endmodule

// File: hdl/triangle_raster_depth_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Scanline triangle rasterizer with a depth store: load, step one pixel,
// clear one depth entry; one result item per input item.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     func, three vertices, shade
//   out_     output     out_valid / out_ready   write_valid, pixel_x/y/color, done_res
//
// Step on screen: from accept to result item, a 27-bit serial divide, then depth
// read, compare and write; in_ready returns with the result item. Row search:
// x and depth of both edges per row tried, each a divide on the shared serial divider or
// a direct copy for a zero-height edge; a load or the last pixel of a span adds
// that search. After reset in_ready stays low while the depth memory sweep runs.
// One item at a time; a stalled result holds the FSM.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test #(
  parameter int SCREEN_W   = 512,
  parameter int SCREEN_H   = 512,
  parameter int DEPTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [8:0]         in_first_x,
  input  logic [8:0]         in_first_y,
  input  logic signed [15:0] in_first_depth,
  input  logic [8:0]         in_second_x,
  input  logic [8:0]         in_second_y,
  input  logic signed [15:0] in_second_depth,
  input  logic [8:0]         in_third_x,
  input  logic [8:0]         in_third_y,
  input  logic signed [15:0] in_third_depth,
  input  logic [23:0]        in_shade,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_write_valid,
  output logic [8:0]         out_pixel_x,
  output logic [8:0]         out_pixel_y,
  output logic [23:0]        out_pixel_color,
  output logic               out_done_res
);
  import trdt_pkg::*;

  localparam int ENTRIES = SCREEN_W * SCREEN_H;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int SHL     = (DEPTH_BITS >= 16) ? DEPTH_BITS - 16 : 0;
  localparam int SHR     = (DEPTH_BITS < 16) ? 16 - DEPTH_BITS : 0;
  localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEEK  = 4'd1;
  localparam logic [3:0] S_EDGE  = 4'd2;
  localparam logic [3:0] S_EWAIT = 4'd3;
  localparam logic [3:0] S_ESPAN = 4'd4;
  localparam logic [3:0] S_PWAIT = 4'd5;
  localparam logic [3:0] S_PCMP  = 4'd6;
  localparam logic [3:0] S_ADV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]                   state_r, state_nxt;
  logic                         active_r, active_nxt;
  logic [9:0]                   row_r, row_nxt;
  logic [9:0]                   col_r, col_nxt;
  logic [1:0]                   e_r, e_nxt;
  logic signed [15:0]           ev_r [4];
  logic signed [15:0]           ev_nxt [4];
  logic [8:0]                   sx_r [3];
  logic [8:0]                   sy_r [3];
  logic signed [15:0]           sz_r [3];
  logic [8:0]                   srt_x [3];
  logic [8:0]                   srt_y [3];
  logic signed [15:0]           srt_z [3];
  logic [23:0]                  color_r, color_nxt;
  logic [9:0]                   span_xs_r, span_xs_nxt;
  logic [9:0]                   span_xe_r, span_xe_nxt;
  logic signed [15:0]           span_zs_r, span_zs_nxt;
  logic signed [15:0]           span_ze_r, span_ze_nxt;
  logic signed [16:0]           base_r, base_nxt;
  logic signed [DEPTH_BITS-1:0] zst_r, zst_nxt;
  logic                         res_wv_r, res_wv_nxt;
  logic [8:0]                   res_x_r, res_x_nxt;
  logic [8:0]                   res_y_r, res_y_nxt;
  logic [23:0]                  res_c_r, res_c_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_wv_r, out_wv_nxt;
  logic [8:0]                   out_x_r, out_x_nxt;
  logic [8:0]                   out_y_r, out_y_nxt;
  logic [23:0]                  out_c_r, out_c_nxt;
  logic                         out_done_r, out_done_nxt;

  div_req_t                     div_req;
  logic                         div_done;
  logic signed [NUM_W-1:0]      div_quo;

  logic                         st_re, st_we, clr_busy;
  logic [ADDR_W-1:0]            st_addr, pix_addr;
  logic signed [DEPTH_BITS-1:0] st_wdata, st_rdata;

  logic                         accept, pix_on;
  logic [1:0]                   ea, eb;
  logic signed [16:0]           va, vb;
  logic signed [10:0]           ya, yb, dy, den_s;
  logic signed [17:0]           dv;
  logic signed [28:0]           prod, num_e;
  logic signed [10:0]           dxp;
  logic signed [16:0]           dzp;
  logic signed [27:0]           prod_p;
  logic signed [15:0]           edge_res, pix_z;
  logic signed [47:0]           zw;
  logic                         span_sel;
  logic signed [15:0]           cxs, cxe, czs, cze;

  // sort vertices by y with the load's tie rule
  always_comb begin
    logic [1:0] lo, hi;
    logic [8:0] tx;
    logic [8:0] ty;
    logic signed [15:0] tz;
    tx = '0;
    ty = '0;
    tz = '0;
    srt_x[0] = in_first_x;   srt_y[0] = in_first_y;   srt_z[0] = in_first_depth;
    srt_x[1] = in_second_x;  srt_y[1] = in_second_y;  srt_z[1] = in_second_depth;
    srt_x[2] = in_third_x;   srt_y[2] = in_third_y;   srt_z[2] = in_third_depth;
    lo = 2'd0;
    hi = 2'd0;
    for (int i = 1; i < 3; i++) begin
      if (srt_y[i] < srt_y[lo]) lo = 2'(i);
      if (srt_y[i] > srt_y[hi]) hi = 2'(i);
    end
    if (lo == 2'd0 && hi == 2'd0) hi = 2'd2;
    if (lo != 2'd0) begin
      tx = srt_x[0]; srt_x[0] = srt_x[lo]; srt_x[lo] = tx;
      ty = srt_y[0]; srt_y[0] = srt_y[lo]; srt_y[lo] = ty;
      tz = srt_z[0]; srt_z[0] = srt_z[lo]; srt_z[lo] = tz;
      if (hi == 2'd0) hi = lo;
    end
    if (hi != 2'd0) begin
      tx = srt_x[2]; srt_x[2] = srt_x[hi]; srt_x[hi] = tx;
      ty = srt_y[2]; srt_y[2] = srt_y[hi]; srt_y[hi] = ty;
      tz = srt_z[2]; srt_z[2] = srt_z[hi]; srt_z[hi] = tz;
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign pix_on   = (int'(col_r) < SCREEN_W) && (int'(row_r) < SCREEN_H);
  assign pix_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(SCREEN_W) + ADDR_W'(col_r));

  // edge operands for the current row and edge index
  always_comb begin
    ea = e_r[1] ? 2'd0 : ((row_r > {1'b0, sy_r[1]}) ? 2'd2 : 2'd0);
    eb = e_r[1] ? 2'd2 : 2'd1;
    va = e_r[0] ? 17'(sz_r[ea]) : $signed({8'b0, sx_r[ea]});
    vb = e_r[0] ? 17'(sz_r[eb]) : $signed({8'b0, sx_r[eb]});
    ya = $signed({2'b00, sy_r[ea]});
    yb = $signed({2'b00, sy_r[eb]});
    den_s = yb - ya;
    dy    = $signed({1'b0, row_r}) - ya;
    dv    = 18'(vb) - 18'(va);
    prod  = dy * dv;
    num_e = den_s[10] ? -prod : prod;
    edge_res = 16'(28'(base_r) + 28'(div_quo));
    dxp    = $signed({1'b0, col_r}) - $signed({1'b0, span_xs_r});
    dzp    = 17'(span_ze_r) - 17'(span_zs_r);
    prod_p = dxp * dzp;
    pix_z  = 16'(28'(span_zs_r) + 28'(div_quo));
    zw     = 48'(pix_z);
    span_sel = ev_r[0] < ev_r[2];
    cxs = span_sel ? ev_r[0] : ev_r[2];
    cxe = span_sel ? ev_r[2] : ev_r[0];
    czs = span_sel ? ev_r[1] : ev_r[3];
    cze = span_sel ? ev_r[3] : ev_r[1];
  end

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    e_nxt       = e_r;
    ev_nxt      = ev_r;
    color_nxt   = color_r;
    span_xs_nxt = span_xs_r;
    span_xe_nxt = span_xe_r;
    span_zs_nxt = span_zs_r;
    span_ze_nxt = span_ze_r;
    base_nxt    = base_r;
    zst_nxt     = zst_r;
    res_wv_nxt  = res_wv_r;
    res_x_nxt   = res_x_r;
    res_y_nxt   = res_y_r;
    res_c_nxt   = res_c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_wv_nxt    = out_wv_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_c_nxt     = out_c_r;
    out_done_nxt  = out_done_r;
    div_req     = '0;
    st_re       = 1'b0;
    st_we       = 1'b0;
    st_addr     = pix_addr;
    st_wdata    = zst_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_wv_nxt = 1'b0;
          res_x_nxt  = '0;
          res_y_nxt  = '0;
          res_c_nxt  = '0;
          state_nxt  = S_FIN;
          unique case (in_func)
            FN_LOAD: begin
              color_nxt = in_shade;
              row_nxt   = {1'b0, srt_y[0]};
              state_nxt = S_SEEK;
            end
            FN_STEP: begin
              if (active_r) begin
                if (pix_on) begin
                  div_req.start = 1'b1;
                  div_req.num   = NUM_W'(prod_p);
                  div_req.den   = DEN_W'(span_xe_r - span_xs_r);
                  state_nxt     = S_PWAIT;
                end else begin
                  state_nxt = S_ADV;
                end
              end
            end
            FN_CLEAR: begin
              if (int'(in_first_x) < SCREEN_W && int'(in_first_y) < SCREEN_H) begin
                st_we    = 1'b1;
                st_addr  = ADDR_W'(ADDR_W'(in_first_y) * ADDR_W'(SCREEN_W)
                                   + ADDR_W'(in_first_x));
                st_wdata = DMIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEEK: begin
        if (row_r > {1'b0, sy_r[2]}) begin
          active_nxt = 1'b0;
          state_nxt  = S_FIN;
        end else begin
          e_nxt     = 2'd0;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (den_s == 11'sd0) begin
          ev_nxt[e_r] = 16'(va);
          e_nxt       = e_r + 2'd1;
          state_nxt   = (e_r == 2'd3) ? S_ESPAN : S_EDGE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(num_e);
          div_req.den   = DEN_W'(den_s[10] ? -den_s : den_s);
          base_nxt      = va;
          state_nxt     = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (div_done) begin
          ev_nxt[e_r] = edge_res;
          e_nxt       = e_r + 2'd1;
          state_nxt   = (e_r == 2'd3) ? S_ESPAN : S_EDGE;
        end
      end
      S_ESPAN: begin
        span_xs_nxt = cxs[9:0];
        span_xe_nxt = cxe[9:0];
        span_zs_nxt = czs;
        span_ze_nxt = cze;
        if (cxs < cxe) begin
          active_nxt = 1'b1;
          col_nxt    = cxs[9:0];
          state_nxt  = S_FIN;
        end else begin
          row_nxt   = row_r + 10'd1;
          state_nxt = S_SEEK;
        end
      end
      S_PWAIT: begin
        if (div_done) begin
          zst_nxt   = DEPTH_BITS'((zw <<< SHL) >>> SHR);
          st_re     = 1'b1;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (zst_r > st_rdata) begin
          st_we      = 1'b1;
          res_wv_nxt = 1'b1;
          res_x_nxt  = col_r[8:0];
          res_y_nxt  = row_r[8:0];
          res_c_nxt  = color_r;
        end
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if (col_r < span_xe_r) begin
          col_nxt   = col_r + 10'd1;
          state_nxt = S_FIN;
        end else begin
          row_nxt   = row_r + 10'd1;
          state_nxt = S_SEEK;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_wv_nxt    = res_wv_r;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_c_nxt     = res_c_r;
          out_done_nxt  = !active_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      e_r         <= '0;
      color_r     <= '0;
      span_xs_r   <= '0;
      span_xe_r   <= '0;
      span_zs_r   <= '0;
      span_ze_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        sx_r[i] <= '0;
        sy_r[i] <= '0;
        sz_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      e_r         <= e_nxt;
      color_r     <= color_nxt;
      span_xs_r   <= span_xs_nxt;
      span_xe_r   <= span_xe_nxt;
      span_zs_r   <= span_zs_nxt;
      span_ze_r   <= span_ze_nxt;
      if (accept && in_func == FN_LOAD) begin
        sx_r <= srt_x;
        sy_r <= srt_y;
        sz_r <= srt_z;
      end
    end
    ev_r       <= ev_nxt;
    base_r     <= base_nxt;
    zst_r      <= zst_nxt;
    res_wv_r   <= res_wv_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_c_r    <= res_c_nxt;
    out_wv_r   <= out_wv_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_c_r    <= out_c_nxt;
    out_done_r <= out_done_nxt;
  end

  trdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  trdt_store #(
    .ENTRIES    (ENTRIES),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (st_re),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata),
    .busy  (clr_busy)
  );

  assign out_valid       = out_valid_r;
  assign out_write_valid = out_wv_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_c_r;
  assign out_done_res    = out_done_r;

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> !clr_busy)
    else $error("depth write during clearing sweep");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_EWAIT || state_r == S_PWAIT))
    else $error("divider result with no waiting state");

  a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && active_r) |->
      (span_xs_r < span_xe_r && col_r >= span_xs_r && col_r <= span_xe_r))
    else $error("active column outside span");

endmodule

// File: tb/triangle_raster_depth_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_tb
// Drives loads, pixel steps, depth clears and idle codes into the rasterizer,
// tracks the depth store and span walk in a local predictor, and compares
// every result item field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test_tb;
  import trdt_pkg::*;

  localparam int SW = 512;
  localparam int SH = 512;
  localparam int ZMIN = -32768;
  localparam int WATCH_LIMIT = 1000000;
  localparam logic [1:0] FN_IDLE = 2'd3;

  typedef struct {
    logic [1:0]         func;
    logic [8:0]         vx[3];
    logic [8:0]         vy[3];
    logic signed [15:0] vz[3];
    logic [23:0]        shade;
  } tri_item_t;

  typedef struct {
    logic        wv;
    logic [8:0]  px;
    logic [8:0]  py;
    logic [23:0] pc;
    logic        done;
  } pix_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [8:0] in_first_x = '0, in_first_y = '0, in_second_x = '0, in_second_y = '0;
  logic [8:0] in_third_x = '0, in_third_y = '0;
  logic signed [15:0] in_first_depth = '0, in_second_depth = '0, in_third_depth = '0;
  logic [23:0] in_shade = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_write_valid, out_done_res;
  logic [8:0] out_pixel_x, out_pixel_y;
  logic [23:0] out_pixel_color;

  triangle_raster_depth_test u_dut (.*);

  initial forever #5 clk = ~clk;

  tri_item_t   pending[$];
  pix_result_t expected_pixels[$];
  tri_item_t   cur_item;
  bit          calm = 0;
  bit          failed = 0;
  int          idle_cycles = 0;

  int zbuf[SW*SH];
  int sx[3], sy[3], sz[3];
  int row, col, span_xs, span_xe, span_zs, span_ze;
  logic [23:0] act_color;
  bit act;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic int edge_at(int y, int v[3], int a, int b);
    longint den, num;
    den = sy[b] - sy[a];
    if (den == 0) return v[a];
    num = longint'(y - sy[a]) * (v[b] - v[a]);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    return v[a] + int'(fdiv(num, den));
  endfunction

  function automatic bit find_span(int r);
    int a0, xa, xb, za, zb;
    a0 = (r > sy[1]) ? 2 : 0;
    xa = edge_at(r, sx, a0, 1);
    za = edge_at(r, sz, a0, 1);
    xb = edge_at(r, sx, 0, 2);
    zb = edge_at(r, sz, 0, 2);
    if (xa < xb) begin
      span_xs = xa; span_xe = xb; span_zs = za; span_ze = zb;
    end else begin
      span_xs = xb; span_xe = xa; span_zs = zb; span_ze = za;
    end
    return span_xs < span_xe;
  endfunction

  function automatic void seek_row(int from);
    for (int r = from; r <= sy[2]; r++) begin
      if (find_span(r)) begin
        row = r;
        col = span_xs;
        act = 1;
        return;
      end
    end
    act = 0;
  endfunction

  function automatic void swap_slots(int a, int b);
    int t;
    t = sx[a]; sx[a] = sx[b]; sx[b] = t;
    t = sy[a]; sy[a] = sy[b]; sy[b] = t;
    t = sz[a]; sz[a] = sz[b]; sz[b] = t;
  endfunction

  function automatic pix_result_t raster_item(tri_item_t it);
    pix_result_t res;
    int lo, hi, z;
    res = '{default: '0};
    case (it.func)
      FN_LOAD: begin
        lo = 0;
        hi = 0;
        for (int i = 0; i < 3; i++) begin
          sx[i] = it.vx[i];
          sy[i] = it.vy[i];
          sz[i] = it.vz[i];
        end
        for (int i = 1; i < 3; i++) begin
          if (sy[i] < sy[lo]) lo = i;
          if (sy[i] > sy[hi]) hi = i;
        end
        if (lo == 0 && hi == 0) hi = 2;
        if (lo != 0) begin
          swap_slots(0, lo);
          if (hi == 0) hi = lo;
        end
        if (hi != 0) swap_slots(2, hi);
        act_color = it.shade;
        seek_row(sy[0]);
      end
      FN_STEP: begin
        if (act) begin
          if (col >= 0 && row >= 0 && col < SW && row < SH) begin
            z = span_zs + int'(fdiv(longint'(col - span_xs) * (span_ze - span_zs),
                                    span_xe - span_xs));
            if (z > zbuf[row*SW + col]) begin
              zbuf[row*SW + col] = z;
              res.wv = 1;
              res.px = col[8:0];
              res.py = row[8:0];
              res.pc = act_color;
            end
          end
          if (col < span_xe) col++;
          else seek_row(row + 1);
        end
      end
      FN_CLEAR: zbuf[int'(it.vy[0])*SW + int'(it.vx[0])] = ZMIN;
      default: ;
    endcase
    res.done = !act;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) expected_pixels.push_back(raster_item(cur_item));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
          cur_item = pending.pop_front();
          in_func <= cur_item.func;
          in_first_x <= cur_item.vx[0];
          in_first_y <= cur_item.vy[0];
          in_first_depth <= cur_item.vz[0];
          in_second_x <= cur_item.vx[1];
          in_second_y <= cur_item.vy[1];
          in_second_depth <= cur_item.vz[1];
          in_third_x <= cur_item.vx[2];
          in_third_y <= cur_item.vy[2];
          in_third_depth <= cur_item.vz[2];
          in_shade <= cur_item.shade;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pix_result_t e;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with nothing expected");
          failed = 1;
        end else begin
          e = expected_pixels.pop_front();
          if (out_write_valid !== e.wv) begin
            $error("write_valid exp %0d got %0d", e.wv, out_write_valid);
            failed = 1;
          end
          if (out_pixel_x !== e.px) begin
            $error("pixel_x exp %0d got %0d", e.px, out_pixel_x);
            failed = 1;
          end
          if (out_pixel_y !== e.py) begin
            $error("pixel_y exp %0d got %0d", e.py, out_pixel_y);
            failed = 1;
          end
          if (out_pixel_color !== e.pc) begin
            $error("pixel_color exp %h got %h", e.pc, out_pixel_color);
            failed = 1;
          end
          if (out_done_res !== e.done) begin
            $error("done_res exp %0d got %0d", e.done, out_done_res);
            failed = 1;
          end
        end
      end
      out_ready <= calm || $urandom_range(99) >= 14;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("triangle_raster_depth_test regression: fail");
      $finish;
    end
  end

  function automatic tri_item_t make_item(logic [1:0] f, int x0, int y0, int z0, int x1,
                                          int y1, int z1, int x2, int y2, int z2,
                                          logic [23:0] c);
    tri_item_t it;
    it.func = f;
    it.vx[0] = 9'(x0); it.vy[0] = 9'(y0); it.vz[0] = 16'(z0);
    it.vx[1] = 9'(x1); it.vy[1] = 9'(y1); it.vz[1] = 16'(z1);
    it.vx[2] = 9'(x2); it.vy[2] = 9'(y2); it.vz[2] = 16'(z2);
    it.shade = c;
    return it;
  endfunction

  function automatic tri_item_t noise_item(logic [1:0] f);
    tri_item_t it;
    it.func = f;
    for (int i = 0; i < 3; i++) begin
      it.vx[i] = 9'($urandom);
      it.vy[i] = 9'($urandom);
      it.vz[i] = 16'($urandom);
    end
    it.shade = 24'($urandom);
    return it;
  endfunction

  task automatic push_steps(int n);
    repeat (n) pending.push_back(make_item(FN_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h0));
  endtask

  task automatic drain;
    wait (pending.size() == 0 && !in_valid && expected_pixels.size() == 0);
  endtask

  task automatic random_batch(int count);
    int bx, by, n, k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(99);
      bx = $urandom_range(SW - 12);
      by = $urandom_range(SH - 12);
      if (k < 70) begin
        pending.push_back(make_item(FN_LOAD,
          bx + $urandom_range(10), by + $urandom_range(10), $urandom,
          bx + $urandom_range(10), by + $urandom_range(10), $urandom,
          bx + $urandom_range(10), by + $urandom_range(10), $urandom, 24'($urandom)));
        k = $urandom_range(45, 1);
        push_steps(k);
        n += k + 1;
        if ($urandom_range(3) == 0) begin
          pending.push_back(make_item(FN_CLEAR, bx + $urandom_range(10),
                                      by + $urandom_range(10), 0, 0, 0, 0, 0, 0, 0,
                                      24'h0));
          push_steps(5);
          n += 6;
        end
      end else if (k < 85) begin
        pending.push_back(noise_item(FN_CLEAR));
        n++;
      end else if (k < 87) begin
        pending.push_back(noise_item(FN_LOAD));
        push_steps(20);
        n += 21;
      end else begin
        pending.push_back(noise_item(2'($urandom_range(3, 1))));
        n++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SW*SH; i++) zbuf[i] = ZMIN;
    for (int i = 0; i < 3; i++) begin
      sx[i] = 0; sy[i] = 0; sz[i] = 0;
    end
    row = 0; col = 0; span_xs = 0; span_xe = 0; span_zs = 0; span_ze = 0;
    act_color = '0;
    act = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    push_steps(1);
    pending.push_back(make_item(FN_IDLE, 511, 511, -1, 511, 511, -1, 511, 511, -1, '1));
    pending.push_back(make_item(FN_LOAD, 10, 20, 100, 14, 20, 200, 12, 20, 300, 24'h1));
    push_steps(1);
    pending.push_back(make_item(FN_LOAD, 20, 30, -32768, 10, 34, 32767, 30, 30, 0,
                                24'hffffff));
    push_steps(8);
    pending.push_back(make_item(FN_LOAD, 20, 30, -32768, 10, 34, 32767, 30, 30, 0,
                                24'h00ff00));
    push_steps(4);
    pending.push_back(make_item(FN_CLEAR, 20, 30, 0, 0, 0, 0, 0, 0, 0, 24'h0));
    pending.push_back(make_item(FN_LOAD, 20, 30, -32768, 10, 34, 32767, 30, 30, 0,
                                24'h123456));
    push_steps(2);
    pending.push_back(make_item(FN_LOAD, 0, 0, -32768, 511, 511, 32767, 0, 511, 0,
                                24'h800000));
    push_steps(3);
    pending.push_back(make_item(FN_LOAD, 511, 505, 32767, 505, 511, 0, 509, 511, -32768,
                                24'h0000ff));
    push_steps(1);
    drain();

    calm = 1;
    random_batch(300);
    drain();
    calm = 0;
    random_batch(1520);
    drain();

    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("triangle_raster_depth_test regression: pass");
    end else begin
      $display("triangle_raster_depth_test regression: fail");
    end
    $finish;
  end
endmodule
